// ===== design/rtte_pkg.sv =====
// Shared constants and types for the round-trip window timeout estimator.
// No dependencies; imported by rtt_window_timeout_estimator_core.
`default_nettype none

package rtte_pkg;

   localparam int PEER_IN_W = 4;
   localparam int SAMPLE_W  = 24;
   localparam int TIMEOUT_W = 25;

   typedef logic [0:0] kind_type;

   localparam kind_type KIND_MEASURE = 1'b0;
   localparam kind_type KIND_QUERY   = 1'b1;

endpackage

`default_nettype wire

// ===== design/rtt_window_timeout_estimator_core.sv =====
// Per-peer RTT sample ring with windowed mean and min/max based timeout.
// Depends on rtte_pkg (field widths, item kind codes).
//
//   channel | dir | handshake          | payload
//   req     | in  | req_valid/req_stall | req_kind, req_peer, req_sample_us
//   rsp     | out | rsp_valid/rsp_stall | rsp_peer_out, rsp_estimate_us, rsp_timeout_us
//
// One item is in work at a time; the walk over the peer's WINDOW ring entries
// goes through the single sample memory read port.
// After reset a clearing pass zeroes the sample and position memories;
// req_stall stays high during it.
// A new request transfer is taken while a finished result waits on rsp_stall.
`default_nettype none

module rtt_window_timeout_estimator_core
   import rtte_pkg::*;
#(
   parameter int NUM_PEERS = 16,
   parameter int WINDOW    = 8
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_stall,
   input  wire  kind_type        req_kind,
   input  wire  [PEER_IN_W-1:0]  req_peer,
   input  wire  [SAMPLE_W-1:0]   req_sample_us,
   output logic                  rsp_valid,
   input  wire                   rsp_stall,
   output logic [PEER_IN_W-1:0]  rsp_peer_out,
   output logic [SAMPLE_W-1:0]   rsp_estimate_us,
   output logic [TIMEOUT_W-1:0]  rsp_timeout_us
);

   localparam int PEER_W   = (NUM_PEERS > 1) ? $clog2(NUM_PEERS) : 1;
   localparam int SLOT_W   = $clog2(WINDOW);
   localparam int STORE_D  = NUM_PEERS * WINDOW;
   localparam int STORE_AW = $clog2(STORE_D);
   localparam int SUM_W    = SAMPLE_W + SLOT_W;
   localparam int SHIFT    = SUM_W + SLOT_W;
   localparam int RECIP_W  = SUM_W + 1;
   localparam int PROD_W   = SUM_W + RECIP_W;
   localparam logic [63:0] RECIP_FULL =
      ((64'd1 << SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
   localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_CLEAR = 4'd1;
   localparam logic [3:0] ST_POS   = 4'd2;
   localparam logic [3:0] ST_UPD   = 4'd3;
   localparam logic [3:0] ST_SCAN  = 4'd4;
   localparam logic [3:0] ST_DRAIN = 4'd5;
   localparam logic [3:0] ST_MULT  = 4'd6;
   localparam logic [3:0] ST_DIFF  = 4'd7;
   localparam logic [3:0] ST_DONE  = 4'd8;

   // memories
   logic [SAMPLE_W-1:0] store_mem [STORE_D];
   logic [SLOT_W-1:0]   pos_mem   [NUM_PEERS];

   // control
   logic [3:0]          state_ff, state_in;
   logic [STORE_AW-1:0] clr_cnt_ff, clr_cnt_in;
   logic [SLOT_W-1:0]   cnt_ff, cnt_in;
   logic                rd_vld_ff, rd_vld_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // datapath
   kind_type            kind_ff;
   logic [PEER_IN_W-1:0] peer_ff;
   logic [PEER_W-1:0]   peer_idx_ff;
   logic [SAMPLE_W-1:0] sample_ff;
   logic [STORE_AW-1:0] base_ff;
   logic [SLOT_W-1:0]   pos_rd_ff;
   logic [SAMPLE_W-1:0] rd_data_ff;
   logic [SUM_W-1:0]    sum_ff;
   logic [SAMPLE_W-1:0] lo_ff;
   logic [SAMPLE_W-1:0] hi_ff;
   logic [PROD_W-1:0]   prod_ff;
   logic [SAMPLE_W-1:0] mean_ff;
   logic [SAMPLE_W-1:0] up_ff;
   logic [SAMPLE_W-1:0] down_ff;
   logic [PEER_IN_W-1:0] rsp_peer_ff;
   logic [SAMPLE_W-1:0] rsp_est_ff;
   logic [TIMEOUT_W-1:0] rsp_to_ff;

   logic                req_xfer;
   logic                peer_ok;
   logic                out_free;
   logic                is_measure;
   logic [SLOT_W-1:0]   pos_next;
   logic [STORE_AW-1:0] rd_addr;
   logic                store_we;
   logic [STORE_AW-1:0] store_waddr;
   logic [SAMPLE_W-1:0] store_wdata;
   logic                pos_we;
   logic [PEER_W-1:0]   pos_waddr;
   logic [SLOT_W-1:0]   pos_wdata;
   logic [SAMPLE_W-1:0] margin;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_xfer   = req_valid && !req_stall;
   assign peer_ok    = (32'(req_peer) < NUM_PEERS);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign is_measure = (kind_ff == KIND_MEASURE);
   assign pos_next   = (pos_rd_ff == SLOT_W'(WINDOW - 1)) ? '0 : pos_rd_ff + SLOT_W'(1);
   assign rd_addr    = base_ff + STORE_AW'(cnt_ff);
   assign margin     = (up_ff < down_ff) ? up_ff : down_ff;

   always_comb begin
      store_we    = 1'b0;
      store_waddr = clr_cnt_ff;
      store_wdata = '0;
      pos_we      = 1'b0;
      pos_waddr   = clr_cnt_ff[PEER_W-1:0];
      pos_wdata   = '0;
      if (state_ff == ST_CLEAR) begin
         store_we = 1'b1;
         pos_we   = (32'(clr_cnt_ff) < NUM_PEERS);
      end else if (state_ff == ST_UPD && is_measure) begin
         store_we    = 1'b1;
         store_waddr = base_ff + STORE_AW'(pos_rd_ff);
         store_wdata = sample_ff;
         pos_we      = 1'b1;
         pos_waddr   = peer_idx_ff;
         pos_wdata   = pos_next;
      end
   end

   always_ff @(posedge clock) begin
      if (store_we) begin
         store_mem[store_waddr] <= store_wdata;
      end
      rd_data_ff <= store_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (pos_we) begin
         pos_mem[pos_waddr] <= pos_wdata;
      end
      pos_rd_ff <= pos_mem[peer_idx_ff];
   end

   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      cnt_in       = cnt_ff;
      rd_vld_in    = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + STORE_AW'(1);
            if (clr_cnt_ff == STORE_AW'(STORE_D - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_xfer) begin
               state_in = peer_ok ? ST_POS : ST_DONE;
            end
         end
         ST_POS: state_in = ST_UPD;
         ST_UPD: begin
            cnt_in   = '0;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            rd_vld_in = 1'b1;
            cnt_in    = cnt_ff + SLOT_W'(1);
            if (cnt_ff == SLOT_W'(WINDOW - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: state_in = ST_MULT;
         ST_MULT:  state_in = ST_DIFF;
         ST_DIFF:  state_in = ST_DONE;
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         cnt_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         cnt_ff       <= cnt_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         kind_ff     <= req_kind;
         peer_ff     <= req_peer;
         peer_idx_ff <= PEER_W'(req_peer);
         sample_ff   <= req_sample_us;
         hi_ff       <= '0;
         mean_ff     <= '0;
         up_ff       <= '0;
         down_ff     <= '0;
      end
      if (state_ff == ST_POS) begin
         base_ff <= STORE_AW'(peer_idx_ff) * STORE_AW'(WINDOW);
      end
      if (state_ff == ST_UPD) begin
         sum_ff <= '0;
         lo_ff  <= '1;
         hi_ff  <= '0;
      end else if (rd_vld_ff) begin
         sum_ff <= sum_ff + SUM_W'(rd_data_ff);
         if (rd_data_ff < lo_ff) begin
            lo_ff <= rd_data_ff;
         end
         if (rd_data_ff > hi_ff) begin
            hi_ff <= rd_data_ff;
         end
      end
      if (state_ff == ST_MULT) begin
         prod_ff <= PROD_W'(sum_ff) * PROD_W'(RECIP);
      end
      if (state_ff == ST_DIFF) begin
         mean_ff <= prod_ff[SHIFT +: SAMPLE_W];
         up_ff   <= hi_ff - prod_ff[SHIFT +: SAMPLE_W];
         down_ff <= prod_ff[SHIFT +: SAMPLE_W] - lo_ff;
      end
      if (state_ff == ST_DONE && out_free) begin
         rsp_peer_ff <= peer_ff;
         rsp_est_ff  <= mean_ff;
         rsp_to_ff   <= TIMEOUT_W'(hi_ff) + TIMEOUT_W'(margin);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_peer_out    = rsp_peer_ff;
   assign rsp_estimate_us = rsp_est_ff;
   assign rsp_timeout_us  = rsp_to_ff;

   // one item in work at a time
   a_no_back_to_back: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> req_stall)
      else $error("request taken while an item is in work");

   // a result only comes out of the final step
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result raised outside the final step");

   // max plus a non-negative margin never drops below the mean
   a_timeout_ge_mean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_to_ff >= TIMEOUT_W'(rsp_est_ff))
      else $error("timeout below estimate");

   // read data is only consumed during the ring walk
   a_rd_in_walk: assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff |-> (state_ff == ST_SCAN || state_ff == ST_DRAIN))
      else $error("sample read outside the ring walk");

endmodule

`default_nettype wire
